// File: rtl/tpbs_pkg.sv
// ----------------------------------------------------------------------------
// tpbs_pkg
// Shared types and constants for the point/bilinear texture sampler.
// ----------------------------------------------------------------------------
package tpbs_pkg;

   localparam int CHANNEL_BITS        = 16;
   localparam int COORD_FRAC_BITS     = 16;
   localparam int MAX_TEXELS_DEFAULT  = 65536;
   localparam int TEXEL_BITS          = 4 * CHANNEL_BITS;

   localparam logic [COORD_FRAC_BITS:0] COORD_ONE = {1'b1, {COORD_FRAC_BITS{1'b0}}};
   localparam logic [CHANNEL_BITS-1:0]  CHAN_ONE  = {CHANNEL_BITS{1'b1}};
   localparam logic [8:0]               DIM_MAX   = 9'd256;

   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_POINT    = 2'd1;
   localparam logic [1:0] OP_BILINEAR = 2'd2;

   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] texel_address;
      logic [16:0] coord_u;
      logic [16:0] coord_v;
      logic [15:0] write_red;
      logic [15:0] write_green;
      logic [15:0] write_blue;
      logic [15:0] write_alpha;
   } req_type;

   typedef struct packed {
      logic [15:0] sample_red;
      logic [15:0] sample_green;
      logic [15:0] sample_blue;
      logic [15:0] sample_alpha;
      logic        write_done;
   } rsp_type;

endpackage

// File: rtl/tpbs_ram.sv
// ----------------------------------------------------------------------------
// tpbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;
endmodule

// File: rtl/texture_point_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// texture_point_bilinear_sampler_unit
// Point and bilinear texture sampler over a stored texel surface.
// ----------------------------------------------------------------------------
// Takes one item per cycle (write, point sample or bilinear sample) and
// presents one result per item, in order. The pipeline has five register
// stages: coordinate scale, neighbor index and row offset, texel address and
// store read, horizontal blend, vertical blend with rounding. The texel store
// is held as four identical copies, each written by every texel write, so the
// four neighbor reads of a bilinear sample go out in one cycle. The whole pipe
// holds when the result register is full and stalled; req_stall is then high.
module texture_point_bilinear_sampler_unit #(
   parameter int MAX_TEXELS = tpbs_pkg::MAX_TEXELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tpbs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpbs_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_write_data
);
   import tpbs_pkg::*;

   localparam int AW = $clog2(MAX_TEXELS);

   // configuration
   logic [8:0] width_ff, height_ff;
   logic [2:0] chan_ff;
   logic [8:0] w_eff, h_eff;
   logic [2:0] nch;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd1;
         height_ff <= 9'd1;
         chan_ff   <= 3'd4;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data;
            CSR_CHANNEL_COUNT: chan_ff   <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // clamp dimensions and channel count into their legal ranges
   always_comb begin
      w_eff = (width_ff == 9'd0) ? 9'd1 : ((width_ff > DIM_MAX) ? DIM_MAX : width_ff);
      h_eff = (height_ff == 9'd0) ? 9'd1 : ((height_ff > DIM_MAX) ? DIM_MAX : height_ff);
      nch   = (chan_ff == 3'd0) ? 3'd1 : ((chan_ff > 3'd4) ? 3'd4 : chan_ff);
   end

   // advance the whole pipe unless the result register is full and stalled
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ---- stage 1: saturate and scale coordinates ----
   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   logic [15:0] s1_addr_ff;
   logic [63:0] s1_wdata_ff;
   logic [24:0] s1_su_ff, s1_sv_ff;
   logic [16:0] sat_u, sat_v;
   logic [7:0]  w_m1, h_m1;

   always_comb begin
      sat_u = (req_data.coord_u > COORD_ONE) ? COORD_ONE : req_data.coord_u;
      sat_v = (req_data.coord_v > COORD_ONE) ? COORD_ONE : req_data.coord_v;
      w_m1  = 8'(w_eff - 9'd1);
      h_m1  = 8'(h_eff - 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_op_ff    <= req_data.op;
         s1_addr_ff  <= req_data.texel_address;
         s1_wdata_ff <= {req_data.write_alpha, req_data.write_blue,
                         req_data.write_green, req_data.write_red};
         s1_su_ff    <= sat_u * w_m1;
         s1_sv_ff    <= sat_v * h_m1;
      end
   end

   // ---- stage 2: neighbor indexes, fractions, row offsets ----
   logic        s2_valid_ff;
   logic [1:0]  s2_op_ff;
   logic [15:0] s2_addr_ff;
   logic [63:0] s2_wdata_ff;
   logic [7:0]  s2_x0_ff, s2_x1_ff;
   logic [15:0] s2_row0_ff, s2_row1_ff, s2_fx_ff, s2_fy_ff;
   logic [7:0]  x0, y0, x1, y1;

   always_comb begin
      x0 = s1_su_ff[23:16];
      y0 = s1_sv_ff[23:16];
      x1 = ({1'b0, x0} + 9'd1 >= w_eff) ? 8'(w_eff - 9'd1) : x0 + 8'd1;
      y1 = ({1'b0, y0} + 9'd1 >= h_eff) ? 8'(h_eff - 9'd1) : y0 + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_op_ff    <= s1_op_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_wdata_ff <= s1_wdata_ff;
         s2_x0_ff    <= x0;
         s2_x1_ff    <= x1;
         s2_fx_ff    <= s1_su_ff[15:0];
         s2_fy_ff    <= s1_sv_ff[15:0];
         s2_row0_ff  <= {8'd0, y0} * {7'd0, w_eff};
         s2_row1_ff  <= {8'd0, y1} * {7'd0, w_eff};
      end
   end

   // ---- stage 3: texel addresses, store write and four reads ----
   logic [15:0] rd_addr [4];
   logic [3:0]  rd_ok;
   logic [63:0] rd_data [4];
   logic        wr_en;

   always_comb begin
      rd_addr[0] = s2_row0_ff + {8'd0, s2_x0_ff};
      rd_addr[1] = s2_row0_ff + {8'd0, s2_x1_ff};
      rd_addr[2] = s2_row1_ff + {8'd0, s2_x0_ff};
      rd_addr[3] = s2_row1_ff + {8'd0, s2_x1_ff};
      for (int k = 0; k < 4; k++) begin
         rd_ok[k] = 32'(rd_addr[k]) < 32'(MAX_TEXELS);
      end
      wr_en = advance && s2_valid_ff && (s2_op_ff == OP_WRITE) &&
              (32'(s2_addr_ff) < 32'(MAX_TEXELS));
   end

   for (genvar g = 0; g < 4; g++) begin : g_copy
      tpbs_ram #(.WIDTH(TEXEL_BITS), .DEPTH(MAX_TEXELS)) u_ram (
         .clock        (clock),
         .write_enable (wr_en),
         .write_address(AW'(s2_addr_ff)),
         .write_data   (s2_wdata_ff),
         .read_enable  (advance),
         .read_address (AW'(rd_addr[g])),
         .read_data    (rd_data[g])
      );
   end

   logic        s3_valid_ff;
   logic [1:0]  s3_op_ff;
   logic [3:0]  s3_ok_ff;
   logic [15:0] s3_fx_ff, s3_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_op_ff <= s2_op_ff;
         s3_ok_ff <= rd_ok;
         s3_fx_ff <= s2_fx_ff;
         s3_fy_ff <= s2_fy_ff;
      end
   end

   // ---- stage 4: horizontal blend per channel ----
   logic [63:0] tex [4];
   logic [16:0] wx0, wx1;
   logic        s4_valid_ff;
   logic [1:0]  s4_op_ff;
   logic [15:0] s4_fy_ff;
   logic [63:0] s4_point_ff;
   logic [32:0] s4_top_ff [4];
   logic [32:0] s4_bot_ff [4];

   always_comb begin
      // drop texels read beyond the store
      for (int k = 0; k < 4; k++) begin
         tex[k] = s3_ok_ff[k] ? rd_data[k] : 64'd0;
      end
      wx1 = {1'b0, s3_fx_ff};
      wx0 = COORD_ONE - wx1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_op_ff    <= s3_op_ff;
         s4_fy_ff    <= s3_fy_ff;
         s4_point_ff <= tex[0];
         for (int k = 0; k < 4; k++) begin
            s4_top_ff[k] <= tex[0][16*k +: 16] * wx0 + tex[1][16*k +: 16] * wx1;
            s4_bot_ff[k] <= tex[2][16*k +: 16] * wx0 + tex[3][16*k +: 16] * wx1;
         end
      end
   end

   // ---- stage 5: vertical blend, round, format fill, result register ----
   logic [16:0] wy0, wy1;
   logic [48:0] vsum [4];
   logic [15:0] chan [4];
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   always_comb begin
      wy1 = {1'b0, s4_fy_ff};
      wy0 = COORD_ONE - wy1;
      for (int k = 0; k < 4; k++) begin
         // round to nearest, ties upward
         vsum[k] = s4_top_ff[k] * wy0 + s4_bot_ff[k] * wy1 + 49'(33'h080000000);
         if (s4_op_ff == OP_POINT) begin
            chan[k] = s4_point_ff[16*k +: 16];
         end else begin
            chan[k] = vsum[k][47:32];
         end
         if (k >= 32'(nch)) begin
            chan[k] = (k == 3) ? CHAN_ONE : 16'd0;
         end
      end
      rsp_in = '0;
      case (s4_op_ff)
         OP_WRITE: rsp_in.write_done = 1'b1;
         OP_POINT, OP_BILINEAR: begin
            rsp_in.sample_red   = chan[0];
            rsp_in.sample_green = chan[1];
            rsp_in.sample_blue  = chan[2];
            rsp_in.sample_alpha = chan[3];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point/bilinear texture sampler. A queue of
// items, built phase by phase under several surface formats, feeds a driver;
// each accepted item is predicted against a shadow texel store and the
// monitor checks every result, in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   import tpbs_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [8:0]  csr_write_data = '0;

   texture_point_bilinear_sampler_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Shadow of the texel store and of the format registers, as the block
   // sees them at the moment an item is accepted.
   logic [63:0] texel_shadow [MAX_TEXELS_DEFAULT];
   // Which addresses the stimulus has written so far; samples only ever
   // touch written texels.
   bit          texel_written [MAX_TEXELS_DEFAULT];
   logic [8:0]  width_reg = 9'd1;
   logic [8:0]  height_reg = 9'd1;
   logic [2:0]  chan_reg = 3'd4;

   req_type     pending_items [$];
   rsp_type     sample_expect [$];
   int          mismatch_count = 0;
   bit          quiet = 1'b0;
   int          req_gap = 0;
   int          rsp_gap = 0;

   function automatic int unsigned eff_dim(input logic [8:0] d);
      if (d < 1) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return d;
   endfunction

   // Split a coordinate into first index, clamped neighbor index and weight.
   function automatic void locate(input logic [16:0] c, input int unsigned dim,
                                  output int unsigned i0, output int unsigned i1,
                                  output longint unsigned fr);
      longint unsigned sc;
      longint unsigned scaled;
      sc = (c > COORD_ONE) ? COORD_ONE : c;
      scaled = sc * (dim - 1);
      i0 = 32'(scaled >> COORD_FRAC_BITS);
      fr = scaled & ((64'd1 << COORD_FRAC_BITS) - 1);
      i1 = (i0 + 1 >= dim) ? dim - 1 : i0 + 1;
   endfunction

   // Linear addresses of the four neighbors under the current format.
   function automatic void corners(input req_type r, output int unsigned a [4],
                                   output longint unsigned fx,
                                   output longint unsigned fy);
      int unsigned x0, x1, y0, y1, w;
      w = eff_dim(width_reg);
      locate(r.coord_u, w, x0, x1, fx);
      locate(r.coord_v, eff_dim(height_reg), y0, y1, fy);
      a[0] = y0 * w + x0;
      a[1] = y0 * w + x1;
      a[2] = y1 * w + x0;
      a[3] = y1 * w + x1;
   endfunction

   // Compute the result of one item and update the shadow store.
   function automatic rsp_type sample_predict(input req_type r);
      rsp_type           o;
      int unsigned       a [4];
      longint unsigned   fx, fy, wx0, wy0, s;
      longint unsigned   res [4];
      logic [63:0]       t [4];
      int unsigned       nch;
      o = '0;
      for (int k = 0; k < 4; k++) res[k] = 0;
      nch = (chan_reg < 1) ? 1 : ((chan_reg > 4) ? 4 : chan_reg);
      if (r.op == OP_WRITE) begin
         texel_shadow[r.texel_address] = {r.write_alpha, r.write_blue,
                                          r.write_green, r.write_red};
         o.write_done = 1'b1;
      end else if (r.op == OP_POINT || r.op == OP_BILINEAR) begin
         corners(r, a, fx, fy);
         for (int k = 0; k < 4; k++) t[k] = texel_shadow[a[k]];
         wx0 = (64'd1 << COORD_FRAC_BITS) - fx;
         wy0 = (64'd1 << COORD_FRAC_BITS) - fy;
         for (int k = 0; k < 4; k++) begin
            if (r.op == OP_POINT) begin
               res[k] = t[0][16*k +: 16];
            end else begin
               s = t[0][16*k +: 16] * wx0 * wy0 + t[1][16*k +: 16] * fx * wy0 +
                   t[2][16*k +: 16] * wx0 * fy + t[3][16*k +: 16] * fx * fy;
               s += 64'd1 << (2 * COORD_FRAC_BITS - 1);
               res[k] = s >> (2 * COORD_FRAC_BITS);
            end
         end
         // Absent channels read as zero, absent alpha as one.
         for (int k = nch; k < 4; k++) res[k] = (k == 3) ? CHAN_ONE : 0;
      end
      o.sample_red   = 16'(res[0]);
      o.sample_green = 16'(res[1]);
      o.sample_blue  = 16'(res[2]);
      o.sample_alpha = 16'(res[3]);
      return o;
   endfunction

   // Driver: present queued items, with random bursts of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) sample_expect.push_back(sample_predict(req_data));
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
            req_gap = $urandom_range(1, 18) - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: stall in random bursts and check each accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_expect.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h", rsp_data);
         end else begin
            rsp_type want;
            want = sample_expect.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected r=%h g=%h b=%h a=%h wd=%b, ",
                            "got r=%h g=%h b=%h a=%h wd=%b"},
                           want.sample_red, want.sample_green, want.sample_blue,
                           want.sample_alpha, want.write_done, rsp_data.sample_red,
                           rsp_data.sample_green, rsp_data.sample_blue,
                           rsp_data.sample_alpha, rsp_data.write_done);
            end
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rsp_gap = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [8:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) width_reg = val;
      else if (idx == CSR_IMAGE_HEIGHT) height_reg = val;
      else if (idx == CSR_CHANNEL_COUNT) chan_reg = val[2:0];
      csr_write_enable <= 1'b0;
   endtask

   // Hold until the driver is empty and every result is back.
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || sample_expect.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return COORD_ONE;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic queue_write(input logic [15:0] addr, input logic [15:0] r,
                              input logic [15:0] g, input logic [15:0] b,
                              input logic [15:0] a);
      req_type it;
      it = '0;
      it.op = OP_WRITE;
      it.texel_address = addr;
      it.coord_u = 17'($urandom);
      it.coord_v = 17'($urandom);
      it.write_red = r;
      it.write_green = g;
      it.write_blue = b;
      it.write_alpha = a;
      texel_written[addr] = 1'b1;
      pending_items.push_back(it);
   endtask

   // Queue a sample; first fill any neighbor texel not yet written.
   task automatic queue_sample(input logic [1:0] op, input logic [16:0] u,
                               input logic [16:0] v);
      req_type         it;
      int unsigned     a [4];
      longint unsigned fx, fy;
      it = '0;
      it.op = op;
      it.texel_address = 16'($urandom);
      it.coord_u = u;
      it.coord_v = v;
      it.write_red = 16'($urandom);
      it.write_green = 16'($urandom);
      it.write_blue = 16'($urandom);
      it.write_alpha = 16'($urandom);
      corners(it, a, fx, fy);
      for (int k = 0; k < 4; k++)
         if (!texel_written[a[k]])
            queue_write(16'(a[k]), rand_chan(), rand_chan(), rand_chan(), rand_chan());
      pending_items.push_back(it);
   endtask

   task automatic queue_unused();
      req_type      it;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(req_type)-1:0];
      it.op = 2'd3;
      pending_items.push_back(it);
   endtask

   task automatic queue_random(input int count);
      int unsigned sel;
      int unsigned area;
      area = eff_dim(width_reg) * eff_dim(height_reg);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 19);
         if (sel < 6)
            queue_write((sel == 0) ? 16'($urandom) : 16'($urandom_range(0, area - 1)),
                        rand_chan(), rand_chan(), rand_chan(), rand_chan());
         else if (sel < 12) queue_sample(OP_POINT, rand_coord(), rand_coord());
         else if (sel < 19) queue_sample(OP_BILINEAR, rand_coord(), rand_coord());
         else queue_unused();
      end
   endtask

   task automatic set_format(input logic [8:0] w, input logic [8:0] h,
                             input logic [8:0] ch);
      drain();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_CHANNEL_COUNT, ch);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: 4x4 RGBA, extremes of channels and coordinates.
      set_format(9'd4, 9'd4, 9'd4);
      queue_write(16'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      queue_write(16'd15, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      queue_write(16'd65535, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
      queue_sample(OP_POINT, 17'd0, 17'd0);
      queue_sample(OP_POINT, COORD_ONE, COORD_ONE);
      queue_sample(OP_POINT, 17'h1FFFF, 17'h10001);
      queue_sample(OP_POINT, 17'd65535, 17'd0);
      queue_sample(OP_BILINEAR, 17'd32768, 17'd32768);
      queue_sample(OP_BILINEAR, 17'd0, COORD_ONE);
      queue_sample(OP_BILINEAR, 17'h1FFFF, 17'd21845);
      queue_sample(OP_BILINEAR, 17'd65535, 17'd65535);
      queue_unused();
      queue_random(100);

      set_format(9'd1, 9'd1, 9'd1);
      queue_random(80);
      set_format(9'd256, 9'd3, 9'd2);
      queue_random(110);
      set_format(9'd2, 9'd256, 9'd3);
      queue_random(110);
      // Zero dimensions and zero channels clamp to one.
      set_format(9'd0, 9'd0, 9'd0);
      queue_random(60);
      // Out-of-range values clamp to 256 and four channels.
      set_format(9'd300, 9'd5, 9'd7);
      queue_random(110);
      set_format(9'd511, 9'd511, 9'd5);
      queue_random(110);
      set_format(9'd7, 9'd9, 9'd4);
      quiet = 1'b1;
      queue_random(120);

      drain();
      repeat (20) @(posedge clock);
      if (sample_expect.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
rtl/tpbs_pkg.sv
rtl/tpbs_ram.sv
rtl/texture_point_bilinear_sampler_unit.sv
test/tb.sv
